// ===== src/winograd_tile_convolution_top_assert.svh =====
// Assertion macros used by the Winograd tile engine controller, wtc_ctrl.
// Each module that includes this file must provide clk and rst_n.
`ifndef WINOGRAD_TILE_CONVOLUTION_TOP_ASSERT_SVH
`define WINOGRAD_TILE_CONVOLUTION_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WTC_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define WTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WTC_ASSERT_NOW(lbl, expr, msg)
`define WTC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/wtc_pkg.sv =====
// Package of the Winograd tile engine: types, constants and transform tables.
// Depends on nothing; used by the controller, datapath, top level and bench.
`default_nettype none
package wtc_pkg;

    localparam int ACC_W = 48;
    localparam int Z_W = 53;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_VALUE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BN_ENABLE   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BN_MEAN     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BN_INV_STD  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BN_GAMMA    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BN_BETA     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RELU_ENABLE = 4'd7;

    localparam logic [1:0] LAST_ROW = 2'd3;
    localparam logic [1:0] LAST_OUT = 2'd2;
    localparam logic [3:0] LAST_IDX = 4'd15;

    typedef enum logic [3:0] {
        S_IDLE, S_UV, S_MUL, S_ADD, S_Z, S_RND, S_BIAS, S_MEAN,
        S_INV, S_GAM, S_BETA, S_RELU, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_UV, OP_MUL, OP_ADD, OP_Z, OP_RND, OP_BIAS,
        OP_MEAN, OP_INV, OP_GAM, OP_BETA, OP_RELU, OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] row;
        logic [3:0] idx;
        logic [1:0] out_i;
        logic [1:0] out_j;
    } cmd_t;

    function automatic logic signed [1:0] bt_coef(input logic [1:0] i, input logic [1:0] k);
        logic signed [1:0] c;
        c = 2'sd0;
        unique case (i)
            2'd0: c = (k == 2'd0) ? 2'sd1 : ((k == 2'd2) ? -2'sd1 : 2'sd0);
            2'd1: c = (k == 2'd1 || k == 2'd2) ? 2'sd1 : 2'sd0;
            2'd2: c = (k == 2'd1) ? -2'sd1 : ((k == 2'd2) ? 2'sd1 : 2'sd0);
            2'd3: c = (k == 2'd1) ? -2'sd1 : ((k == 2'd3) ? 2'sd1 : 2'sd0);
            default: c = 2'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [2:0] g2_coef(input logic [1:0] i, input logic c);
        logic signed [2:0] v;
        v = 3'sd0;
        unique case (i)
            2'd0: v = c ? 3'sd0 : 3'sd2;
            2'd1: v = 3'sd1;
            2'd2: v = c ? -3'sd1 : 3'sd1;
            2'd3: v = c ? 3'sd2 : 3'sd0;
            default: v = 3'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] at_coef(input logic [1:0] i, input logic [1:0] k);
        logic signed [1:0] c;
        c = 2'sd0;
        unique case (i)
            2'd0: c = (k == 2'd3) ? 2'sd0 : 2'sd1;
            2'd1: c = (k == 2'd1) ? 2'sd1 : ((k == 2'd2) ? -2'sd1 : 2'sd0);
            2'd2: c = (k == 2'd0) ? 2'sd0 : 2'sd1;
            default: c = 2'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [OUT_W-1:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (x < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = x[OUT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [63:0] x);
        logic signed [ACC_W-1:0] r;
        if (x > 64'sh0000_7FFF_FFFF_FFFF)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (x < -64'sh0000_8000_0000_0000)
            r = 48'sh8000_0000_0000;
        else
            r = x[ACC_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/wtc_if.sv =====
// Request channel interfaces of the Winograd tile engine.
// Does not depend on wtc_pkg; the result and configuration widths are written as literals.
`default_nettype none
interface wtc_in_if #(parameter int DW = 16);
    logic          valid;
    logic          ready;
    logic [DW-1:0] data_a;
    logic [DW-1:0] data_b;
    logic [DW-1:0] data_c;
    logic [DW-1:0] data_d;
    logic [DW-1:0] weight_a;
    logic [DW-1:0] weight_b;
    logic          final_channel;
    modport source (output valid, data_a, data_b, data_c, data_d, weight_a, weight_b,
                    final_channel, input ready);
    modport sink (input valid, data_a, data_b, data_c, data_d, weight_a, weight_b,
                  final_channel, output ready);
endinterface

interface wtc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_a;
    logic [31:0] out_b;
    logic [31:0] out_c;
    logic [1:0]  out_row;
    logic        row_last;
    modport source (output valid, out_a, out_b, out_c, out_row, row_last, input ready);
    modport sink (input valid, out_a, out_b, out_c, out_row, row_last, output ready);
endinterface

interface wtc_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] wdata;
    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// ===== src/winograd_tile_convolution_top.sv =====
// Rows 0 to 2 of a tile are only stored. Row 3 starts accumulation: the single
// multiplier serves the 16 transform products one at a time, each through S_UV,
// S_MUL and S_ADD. A final row 3 adds the output transform and post-processing, one
// output element at a time, plus the wait for each output row to be taken.
// Reset clears the accumulators and the row counter and sets the configuration registers to defaults.
`default_nettype none
module winograd_tile_convolution_top #(
    parameter int DATA_WIDTH = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    wtc_in_if.sink   in_ch,
    wtc_out_if.source out_ch,
    wtc_cfg_if.sink  cfg_ch
);
    import wtc_pkg::*;

    cmd_t       cmd;
    logic [1:0] out_row_q;

    assign cfg_ch.ready = 1'b1;

    wtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_final  (in_ch.final_channel),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    wtc_datapath #(.DW(DATA_WIDTH)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_a    (in_ch.data_a),
        .data_b    (in_ch.data_b),
        .data_c    (in_ch.data_c),
        .data_d    (in_ch.data_d),
        .weight_a  (in_ch.weight_a),
        .weight_b  (in_ch.weight_b),
        .cfg_we    (cfg_ch.valid),
        .cfg_index (cfg_ch.index),
        .cfg_wdata (cfg_ch.wdata),
        .res_a     (out_ch.out_a),
        .res_b     (out_ch.out_b),
        .res_c     (out_ch.out_c)
    );

    assign out_row_q       = cmd.out_i;
    assign out_ch.out_row  = out_row_q;
    assign out_ch.row_last = (out_row_q == LAST_OUT);

endmodule
`default_nettype wire

// ===== src/wtc_ctrl.sv =====
// Sequencer of the Winograd tile engine: row counting, accumulate and output loops.
// Depends on wtc_pkg and the assertion macro header.
`default_nettype none
`include "winograd_tile_convolution_top_assert.svh"
module wtc_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        in_final,
    output logic             out_valid,
    input  wire logic        out_ready,
    output wtc_pkg::cmd_t    cmd
);
    import wtc_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [3:0] idx_reg, idx_next;
    logic [1:0] i_reg, i_next;
    logic [1:0] j_reg, j_next;
    logic       final_reg, final_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= 2'd0;
            idx_reg   <= 4'd0;
            i_reg     <= 2'd0;
            j_reg     <= 2'd0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            idx_reg   <= idx_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            final_reg <= final_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        idx_next   = idx_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        final_next = final_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    row_next = row_reg + 2'd1;
                    if (row_reg == LAST_ROW)
                    begin
                        final_next = in_final;
                        idx_next   = 4'd0;
                        state_next = S_UV;
                    end
                end
            end
            S_UV:  state_next = S_MUL;
            S_MUL: state_next = S_ADD;
            S_ADD:
            begin
                idx_next = idx_reg + 4'd1;
                if (idx_reg != LAST_IDX)
                    state_next = S_UV;
                else if (final_reg)
                begin
                    i_next     = 2'd0;
                    j_next     = 2'd0;
                    state_next = S_Z;
                end
                else
                    state_next = S_IDLE;
            end
            S_Z:
            begin
                idx_next = idx_reg + 4'd1;
                if (idx_reg == LAST_IDX)
                    state_next = S_RND;
            end
            S_RND:  state_next = S_BIAS;
            S_BIAS: state_next = S_MEAN;
            S_MEAN: state_next = S_INV;
            S_INV:  state_next = S_GAM;
            S_GAM:  state_next = S_BETA;
            S_BETA: state_next = S_RELU;
            S_RELU:
            begin
                if (j_reg == LAST_OUT)
                    state_next = S_OUT;
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_Z;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    j_next = 2'd0;
                    if (i_reg == LAST_OUT)
                    begin
                        i_next     = 2'd0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 2'd1;
                        state_next = S_Z;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
        cmd.row   = row_reg;
        cmd.idx   = idx_reg;
        cmd.out_i = i_reg;
        cmd.out_j = j_reg;
        unique case (state_reg)
            S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_UV:    cmd.op = OP_UV;
            S_MUL:   cmd.op = OP_MUL;
            S_ADD:   cmd.op = OP_ADD;
            S_Z:     cmd.op = OP_Z;
            S_RND:   cmd.op = OP_RND;
            S_BIAS:  cmd.op = OP_BIAS;
            S_MEAN:  cmd.op = OP_MEAN;
            S_INV:   cmd.op = OP_INV;
            S_GAM:   cmd.op = OP_GAM;
            S_BETA:  cmd.op = OP_BETA;
            S_RELU:  cmd.op = OP_RELU;
            S_OUT:   cmd.op = (out_ready && i_reg == LAST_OUT) ? OP_CLEAR : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    `WTC_ASSERT_NOW(a_no_overlap, !(in_ready && out_valid), "input taken while a row is pending")
    `WTC_ASSERT_NEXT(a_row3_starts, state_reg == S_IDLE && in_valid && row_reg == LAST_ROW,
        state_reg == S_UV && row_reg == 2'd0, "tile row 3 did not start accumulation")
    `WTC_ASSERT_NOW(a_out_row_range, !out_valid || i_reg != LAST_ROW, "output row out of range")
    `WTC_ASSERT_NEXT(a_partial_done, state_reg == S_ADD && idx_reg == LAST_IDX && !final_reg,
        state_reg == S_IDLE, "non-final tile did not return to idle")

endmodule
`default_nettype wire

// ===== src/wtc_datapath.sv =====
// Datapath of the Winograd tile engine: row storage, transforms, one product multiplier,
// accumulators, output transform and the post-processing chain. Depends on wtc_pkg.
`default_nettype none
module wtc_datapath #(
    parameter int DW = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire wtc_pkg::cmd_t                  cmd,
    input  wire logic [DW-1:0]                  data_a,
    input  wire logic [DW-1:0]                  data_b,
    input  wire logic [DW-1:0]                  data_c,
    input  wire logic [DW-1:0]                  data_d,
    input  wire logic [DW-1:0]                  weight_a,
    input  wire logic [DW-1:0]                  weight_b,
    input  wire logic                           cfg_we,
    input  wire logic [wtc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wtc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic [wtc_pkg::OUT_W-1:0]           res_a,
    output logic [wtc_pkg::OUT_W-1:0]           res_b,
    output logic [wtc_pkg::OUT_W-1:0]           res_c
);
    import wtc_pkg::*;

    localparam int UW = DW + 4;
    localparam int VW = DW + 2;
    localparam int PW = UW + VW;
    localparam int EW = (PW > ACC_W) ? PW : ACC_W;

    logic                    bias_en_reg, bn_en_reg, relu_en_reg;
    logic signed [31:0]      bias_reg, mean_reg, beta_reg;
    logic signed [15:0]      inv_reg, gamma_reg;

    logic signed [DW-1:0]    tile_reg [12];
    logic signed [DW-1:0]    row3_reg [4];
    logic signed [DW-1:0]    filt_reg [4];
    logic signed [UW-1:0]    u_reg, u_next;
    logic signed [VW-1:0]    v_reg, v_next;
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg [16];
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic signed [OUT_W-1:0] f_reg, f_next;
    logic signed [OUT_W-1:0] res_reg [3];

    logic signed [DW-1:0]    in_row [4];
    logic signed [DW-1:0]    dmat [4][4];
    logic signed [VW-1:0]    wrow [4];
    logic signed [DW+1:0]    a0, a1;
    logic signed [PW-1:0]    prod_full;
    logic signed [EW-1:0]    prod_x;
    logic signed [ACC_W-1:0] acc_sel;
    logic signed [1:0]       zc;
    logic signed [Z_W-1:0]   z_term;
    logic signed [Z_W-1:0]   z_rnd;
    logic signed [47:0]      scaled;
    logic signed [15:0]      factor;

    assign in_row[0] = data_a;
    assign in_row[1] = data_b;
    assign in_row[2] = data_c;
    assign in_row[3] = data_d;

    always_comb
    begin
        for (int m = 0; m < 3; m++)
            for (int k = 0; k < 4; k++)
                dmat[m][k] = tile_reg[m * 4 + k];
        for (int k = 0; k < 4; k++)
            dmat[3][k] = row3_reg[k];
    end

    // Filter transform element (i, j) as 4*U and tile transform element as V.
    always_comb
    begin
        logic signed [DW+1:0] g00, g01, g10, g11;
        logic signed [DW+1:0] f0, f1, f2, f3;
        logic signed [UW-1:0] h0, h1, x0, x1;
        logic signed [VW-1:0] b, dx;
        g00 = (DW+2)'(g2_coef(cmd.idx[3:2], 1'b0));
        g01 = (DW+2)'(g2_coef(cmd.idx[3:2], 1'b1));
        f0  = (DW+2)'(filt_reg[0]);
        f1  = (DW+2)'(filt_reg[1]);
        f2  = (DW+2)'(filt_reg[2]);
        f3  = (DW+2)'(filt_reg[3]);
        a0  = g00 * f0 + g01 * f2;
        a1  = g00 * f1 + g01 * f3;
        g10 = (DW+2)'(g2_coef(cmd.idx[1:0], 1'b0));
        g11 = (DW+2)'(g2_coef(cmd.idx[1:0], 1'b1));
        h0  = UW'(g10);
        h1  = UW'(g11);
        x0  = UW'(a0);
        x1  = UW'(a1);
        u_next = h0 * x0 + h1 * x1;
        for (int k = 0; k < 4; k++)
        begin
            wrow[k] = '0;
            for (int m = 0; m < 4; m++)
            begin
                b  = VW'(bt_coef(cmd.idx[3:2], 2'(m)));
                dx = VW'(dmat[m][k]);
                wrow[k] = wrow[k] + b * dx;
            end
        end
        v_next = '0;
        for (int k = 0; k < 4; k++)
        begin
            b = VW'(bt_coef(cmd.idx[1:0], 2'(k)));
            v_next = v_next + b * wrow[k];
        end
    end

    always_comb
    begin
        logic signed [EW-1:0] hi, lo;
        prod_full = PW'(u_reg) * PW'(v_reg);
        prod_x    = EW'(prod_full);
        hi        = EW'(48'sh7FFF_FFFF_FFFF);
        lo        = EW'(48'sh8000_0000_0000);
        if (prod_x > hi)
            prod_next = 48'sh7FFF_FFFF_FFFF;
        else if (prod_x < lo)
            prod_next = 48'sh8000_0000_0000;
        else
            prod_next = prod_x[ACC_W-1:0];
    end

    assign acc_sel = acc_reg[cmd.idx];
    assign zc      = at_coef(cmd.out_i, cmd.idx[3:2]) * at_coef(cmd.out_j, cmd.idx[1:0]);
    assign z_term  = (zc == 2'sd1) ? Z_W'(acc_sel) :
                     ((zc == -2'sd1) ? -Z_W'(acc_sel) : '0);
    assign z_next  = ((cmd.idx == 4'd0) ? '0 : z_reg) + z_term;
    assign z_rnd   = (z_reg + Z_W'(2)) >>> 2;
    assign factor  = (cmd.op == OP_INV) ? inv_reg : gamma_reg;
    assign scaled  = 48'(f_reg) * 48'(factor) + 48'sd128;

    always_comb
    begin
        f_next = f_reg;
        unique case (cmd.op)
            OP_RND:  f_next = sat32(64'(z_rnd));
            OP_BIAS: f_next = bias_en_reg ? sat32(64'(f_reg) + 64'(bias_reg)) : f_reg;
            OP_MEAN: f_next = bn_en_reg ? sat32(64'(f_reg) - 64'(mean_reg)) : f_reg;
            OP_INV,
            OP_GAM:  f_next = bn_en_reg ? sat32(64'(scaled >>> 8)) : f_reg;
            OP_BETA: f_next = bn_en_reg ? sat32(64'(f_reg) + 64'(beta_reg)) : f_reg;
            default: f_next = f_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_en_reg <= 1'b0;
            bias_reg    <= '0;
            bn_en_reg   <= 1'b0;
            mean_reg    <= '0;
            inv_reg     <= 16'sd256;
            gamma_reg   <= 16'sd256;
            beta_reg    <= '0;
            relu_en_reg <= 1'b0;
            for (int n = 0; n < 16; n++)
                acc_reg[n] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BIAS_ENABLE: bias_en_reg <= cfg_wdata[0];
                    REG_BIAS_VALUE:  bias_reg    <= cfg_wdata;
                    REG_BN_ENABLE:   bn_en_reg   <= cfg_wdata[0];
                    REG_BN_MEAN:     mean_reg    <= cfg_wdata;
                    REG_BN_INV_STD:  inv_reg     <= cfg_wdata[15:0];
                    REG_BN_GAMMA:    gamma_reg   <= cfg_wdata[15:0];
                    REG_BN_BETA:     beta_reg    <= cfg_wdata;
                    REG_RELU_ENABLE: relu_en_reg <= cfg_wdata[0];
                    default:         ;
                endcase
            end
            if (cmd.op == OP_ADD)
                acc_reg[cmd.idx] <= sat48(64'(acc_reg[cmd.idx]) + 64'(prod_reg));
            else if (cmd.op == OP_CLEAR)
                for (int n = 0; n < 16; n++)
                    acc_reg[n] <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (cmd.row == LAST_ROW)
                    row3_reg[k] <= in_row[k];
                else
                    tile_reg[{cmd.row, 2'(k)}] <= in_row[k];
            end
            if (cmd.row[1] == 1'b0)
            begin
                filt_reg[{cmd.row[0], 1'b0}] <= weight_a;
                filt_reg[{cmd.row[0], 1'b1}] <= weight_b;
            end
        end
        if (cmd.op == OP_UV)
        begin
            u_reg <= u_next;
            v_reg <= v_next;
        end
        if (cmd.op == OP_MUL)
            prod_reg <= prod_next;
        if (cmd.op == OP_Z)
            z_reg <= z_next;
        f_reg <= f_next;
        if (cmd.op == OP_RELU)
            res_reg[cmd.out_j] <= (relu_en_reg && f_reg < 0) ? '0 : f_reg;
    end

    assign res_a = res_reg[0];
    assign res_b = res_reg[1];
    assign res_c = res_reg[2];

endmodule
`default_nettype wire

// ===== bench/winograd_tile_convolution_top_tb.sv =====
// Self-checking bench for the Winograd F(3x3,2x2) tile engine top level.
// Depends on wtc_pkg and the request interfaces in wtc_if; predicts every
// output row from tile and filter requests and compares it field by field.
`timescale 1ns / 100ps
`default_nettype none
module winograd_tile_convolution_top_tb;
    import wtc_pkg::*;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic [1:0]         row;
        logic               last;
    } out_row_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   rows_seen;
    int   tiles_sent;
    int   calm;

    wtc_in_if #(.DW(16)) in_ch();
    wtc_out_if out_ch();
    wtc_cfg_if cfg_ch();

    winograd_tile_convolution_top #(.DATA_WIDTH(16)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_ch(cfg_ch.sink)
    );

    // Predictor state.
    logic        p_bias_en;
    longint      p_bias;
    logic        p_bn_en;
    longint      p_mean;
    longint      p_inv;
    longint      p_gam;
    longint      p_beta;
    logic        p_relu_en;
    longint      tile_mem[12];
    longint      filt_mem[4];
    int          row_idx;
    longint      sums[16];
    out_row_t    expected_rows[$];

    initial begin
        clk = 1'b0;
    end
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint clampl(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint s32(longint x);
        return clampl(x, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint fshift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint mul48(longint a, longint b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        if (p > 128'sd140737488355327)
            return 64'sd140737488355327;
        if (p < -128'sd140737488355328)
            return -64'sd140737488355328;
        return longint'(p);
    endfunction

    function automatic int bt(int i, int k);
        int t[4][4] = '{'{1, 0, -1, 0}, '{0, 1, 1, 0}, '{0, -1, 1, 0}, '{0, -1, 0, 1}};
        return t[i][k];
    endfunction

    function automatic int g2(int i, int c);
        int t[4][2] = '{'{2, 0}, '{1, 1}, '{1, -1}, '{0, 2}};
        return t[i][c];
    endfunction

    function automatic int at(int i, int k);
        int t[3][4] = '{'{1, 1, 1, 0}, '{0, 1, -1, 0}, '{0, 1, 1, 1}};
        return t[i][k];
    endfunction

    function automatic longint post_process(longint z);
        longint v;
        v = s32(fshift(z + 2, 2));
        if (p_bias_en)
            v = s32(v + p_bias);
        if (p_bn_en) begin
            v = s32(v - p_mean);
            v = s32(fshift(v * p_inv + 128, 8));
            v = s32(fshift(v * p_gam + 128, 8));
            v = s32(v + p_beta);
        end
        if (p_relu_en && v < 0)
            v = 0;
        return v;
    endfunction

    task automatic predict_tile_row(input logic [15:0] d[4], input logic [15:0] wa,
                                    input logic [15:0] wb, input logic fin);
        longint dd[4][4];
        longint fa[4][2];
        longint tv[4][4];
        longint m[16];
        longint zw[3][4];
        longint u4;
        longint v;
        longint z;
        out_row_t r;
        int i;
        int j;
        int k;
        int cur;
        cur = row_idx;
        row_idx = (row_idx + 1) % 4;
        if (cur < 2) begin
            filt_mem[cur * 2] = longint'($signed(wa));
            filt_mem[cur * 2 + 1] = longint'($signed(wb));
        end
        if (cur < 3) begin
            for (i = 0; i < 4; i++)
                tile_mem[cur * 4 + i] = longint'($signed(d[i]));
            return;
        end
        for (i = 0; i < 3; i++)
            for (j = 0; j < 4; j++)
                dd[i][j] = tile_mem[i * 4 + j];
        for (j = 0; j < 4; j++)
            dd[3][j] = longint'($signed(d[j]));
        for (i = 0; i < 4; i++)
            for (j = 0; j < 2; j++)
                fa[i][j] = g2(i, 0) * filt_mem[j] + g2(i, 1) * filt_mem[2 + j];
        for (i = 0; i < 4; i++)
            for (j = 0; j < 4; j++) begin
                tv[i][j] = 0;
                for (k = 0; k < 4; k++)
                    tv[i][j] += bt(i, k) * dd[k][j];
            end
        for (i = 0; i < 4; i++)
            for (j = 0; j < 4; j++) begin
                u4 = fa[i][0] * g2(j, 0) + fa[i][1] * g2(j, 1);
                v = 0;
                for (k = 0; k < 4; k++)
                    v += tv[i][k] * bt(j, k);
                sums[i * 4 + j] = clampl(sums[i * 4 + j] + mul48(u4, v),
                                         -64'sd140737488355328, 64'sd140737488355327);
            end
        if (!fin)
            return;
        for (i = 0; i < 16; i++) begin
            m[i] = sums[i];
            sums[i] = 0;
        end
        for (i = 0; i < 3; i++)
            for (j = 0; j < 4; j++) begin
                zw[i][j] = 0;
                for (k = 0; k < 4; k++)
                    zw[i][j] += at(i, k) * m[k * 4 + j];
            end
        for (i = 0; i < 3; i++) begin
            z = 0;
            for (k = 0; k < 4; k++)
                z += zw[i][k] * at(0, k);
            r.a = 32'(post_process(z));
            z = 0;
            for (k = 0; k < 4; k++)
                z += zw[i][k] * at(1, k);
            r.b = 32'(post_process(z));
            z = 0;
            for (k = 0; k < 4; k++)
                z += zw[i][k] * at(2, k);
            r.c = 32'(post_process(z));
            r.row = 2'(i);
            r.last = (i == 2);
            expected_rows.push_back(r);
        end
    endtask

    function automatic logic idle_now();
        return (calm == 0) && ($urandom_range(99) < 33);
    endfunction

    task automatic send_tile_row(input logic [15:0] d[4], input logic [15:0] wa,
                                 input logic [15:0] wb, input logic fin);
        while (idle_now()) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_a <= d[0];
        in_ch.data_b <= d[1];
        in_ch.data_c <= d[2];
        in_ch.data_d <= d[3];
        in_ch.weight_a <= wa;
        in_ch.weight_b <= wb;
        in_ch.final_channel <= fin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_tile_row(d, wa, wb, fin);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_BIAS_ENABLE: p_bias_en = val[0];
            REG_BIAS_VALUE:  p_bias = longint'($signed(val));
            REG_BN_ENABLE:   p_bn_en = val[0];
            REG_BN_MEAN:     p_mean = longint'($signed(val));
            REG_BN_INV_STD:  p_inv = longint'($signed(val[15:0]));
            REG_BN_GAMMA:    p_gam = longint'($signed(val[15:0]));
            REG_BN_BETA:     p_beta = longint'($signed(val));
            REG_RELU_ENABLE: p_relu_en = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_val(int mode);
        case (mode)
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    // One tile: four rows, final as asked on the last row, random before.
    task automatic send_tile(input int mode, input logic fin);
        logic [15:0] d[4];
        int r;
        int i;
        for (r = 0; r < 4; r++) begin
            for (i = 0; i < 4; i++)
                d[i] = rand_val(mode);
            send_tile_row(d, rand_val(mode), rand_val(mode), (r == 3) ? fin : 1'($urandom));
        end
    endtask

    task automatic test_extremes();
        send_tile(0, 1'b1);
        send_tile(1, 1'b1);
        send_tile(0, 1'b0);
        send_tile(1, 1'b0);
        send_tile(2, 1'b1);
        send_tile(3, 1'b1);
        wait_drained();
    endtask

    task automatic test_post_processing();
        write_reg(REG_BIAS_ENABLE, 32'd1);
        write_reg(REG_BIAS_VALUE, 32'h7FFF_FFFF);
        write_reg(REG_RELU_ENABLE, 32'd1);
        write_reg(4'd12, 32'hFFFF_FFFF);
        send_tile(3, 1'b1);
        send_tile(2, 1'b1);
        wait_drained();
        write_reg(REG_BIAS_VALUE, 32'h8000_0000);
        write_reg(REG_BN_ENABLE, 32'd1);
        write_reg(REG_BN_MEAN, 32'h8000_0000);
        write_reg(REG_BN_INV_STD, 32'h0000_8000);
        write_reg(REG_BN_GAMMA, 32'h0000_7FFF);
        write_reg(REG_BN_BETA, 32'h7FFF_FFFF);
        send_tile(3, 1'b1);
        send_tile(2, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_tiles();
        int n;
        for (n = 0; n < 48; n++) begin
            if (n % 8 == 0) begin
                wait_drained();
                write_reg(REG_BIAS_ENABLE, 32'($urandom_range(1)));
                write_reg(REG_BIAS_VALUE, $urandom);
                write_reg(REG_BN_ENABLE, 32'($urandom_range(1)));
                write_reg(REG_BN_MEAN, 32'($signed(16'($urandom))));
                write_reg(REG_BN_INV_STD, 32'($urandom_range(1023)));
                write_reg(REG_BN_GAMMA, $urandom);
                write_reg(REG_BN_BETA, 32'($signed(20'($urandom))));
                write_reg(REG_RELU_ENABLE, 32'($urandom_range(1)));
            end
            calm = (n >= 20 && n < 28) ? 1 : 0;
            send_tile($urandom_range(3), ($urandom_range(2) != 0));
            tiles_sent++;
        end
        calm = 0;
        wait_drained();
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !idle_now();
    end

    always @(posedge clk) begin
        out_row_t e;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            rows_seen++;
            if (expected_rows.size() == 0) begin
                errors++;
                $display("%0t: unexpected output row %0d", $time, out_ch.out_row);
            end
            else begin
                e = expected_rows.pop_front();
                if (out_ch.out_a !== e.a || out_ch.out_b !== e.b || out_ch.out_c !== e.c ||
                    out_ch.out_row !== e.row || out_ch.row_last !== e.last) begin
                    errors++;
                    $display("%0t: mismatch expected %h %h %h row %0d last %0b", $time,
                             e.a, e.b, e.c, e.row, e.last);
                    $display("%0t:          actual   %h %h %h row %0d last %0b", $time,
                             out_ch.out_a, out_ch.out_b, out_ch.out_c, out_ch.out_row,
                             out_ch.row_last);
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        errors = 0;
        rows_seen = 0;
        tiles_sent = 0;
        calm = 0;
        p_bias_en = 0;
        p_bias = 0;
        p_bn_en = 0;
        p_mean = 0;
        p_inv = 256;
        p_gam = 256;
        p_beta = 0;
        p_relu_en = 0;
        row_idx = 0;
        foreach (sums[i])
            sums[i] = 0;
        foreach (tile_mem[i])
            tile_mem[i] = 0;
        foreach (filt_mem[i])
            filt_mem[i] = 0;
        in_ch.valid = 1'b0;
        in_ch.data_a = '0;
        in_ch.data_b = '0;
        in_ch.data_c = '0;
        in_ch.data_d = '0;
        in_ch.weight_a = '0;
        in_ch.weight_b = '0;
        in_ch.final_channel = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_post_processing();
        test_random_tiles();
        $display("Covered %0d random tiles and %0d checked output rows,", tiles_sent, rows_seen);
        $display("with bias, batch norm and ReLU settings varied across phases.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
